### rtl/pzb_pkg.sv
// Shared types and constants for the proximity zone beeper.
// Holds the beat payload structs, zone codes, register indexes and reset values.
// No dependencies.
package pzb_pkg;

  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [2:0] {
    ZN_SAFE     = 3'd0,
    ZN_WARNING  = 3'd1,
    ZN_CAUTION  = 3'd2,
    ZN_DANGER   = 3'd3,
    ZN_CRITICAL = 3'd4
  } pzb_zone_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAFE_THR    = 3'd0,
    CFG_WARNING_THR = 3'd1,
    CFG_CAUTION_THR = 3'd2,
    CFG_DANGER_THR  = 3'd3,
    CFG_WARNING_PAT = 3'd4,
    CFG_CAUTION_PAT = 3'd5,
    CFG_DANGER_PAT  = 3'd6,
    CFG_CRIT_FREQ   = 3'd7
  } pzb_cfg_idx_e;

  typedef struct packed {
    logic [15:0] beep_period;
    logic [15:0] beep_len;
    logic [15:0] frequency;
  } pzb_pattern_t;

  typedef struct packed {
    logic [15:0]  safe_threshold;
    logic [15:0]  warning_threshold;
    logic [15:0]  caution_threshold;
    logic [15:0]  danger_threshold;
    pzb_pattern_t warning_pattern;
    pzb_pattern_t caution_pattern;
    pzb_pattern_t danger_pattern;
    logic [15:0]  critical_frequency;
  } pzb_cfg_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        sample_valid;
    logic [31:0] now_ms;
  } pzb_in_t;

  typedef struct packed {
    logic [15:0] tone_frequency;
    logic        tone_on;
    pzb_zone_e   zone;
  } pzb_out_t;

  typedef struct packed {
    pzb_zone_e   zone;
    logic [31:0] last_toggle_ms;
    logic        beeper_on;
  } pzb_state_t;

  localparam logic [15:0]  SafeThrRst    = 16'd800;
  localparam logic [15:0]  WarningThrRst = 16'd480;
  localparam logic [15:0]  CautionThrRst = 16'd240;
  localparam logic [15:0]  DangerThrRst  = 16'd80;
  localparam pzb_pattern_t WarningPatRst = '{16'd1000, 16'd100, 16'd500};
  localparam pzb_pattern_t CautionPatRst = '{16'd500, 16'd100, 16'd1000};
  localparam pzb_pattern_t DangerPatRst  = '{16'd250, 16'd80, 16'd1500};
  localparam logic [15:0]  CritFreqRst   = 16'd2000;

endpackage

### rtl/pzb_cfg_regs.sv
// Configuration register file for the proximity zone beeper.
// Depends on pzb_pkg for the register indexes, reset values and pzb_cfg_t.
module pzb_cfg_regs
  import pzb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output pzb_cfg_t            cfg_o
);

  pzb_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safe_threshold     <= SafeThrRst;
      cfg_q.warning_threshold  <= WarningThrRst;
      cfg_q.caution_threshold  <= CautionThrRst;
      cfg_q.danger_threshold   <= DangerThrRst;
      cfg_q.warning_pattern    <= WarningPatRst;
      cfg_q.caution_pattern    <= CautionPatRst;
      cfg_q.danger_pattern     <= DangerPatRst;
      cfg_q.critical_frequency <= CritFreqRst;
    end else if (cfg_we_i) begin
      case (pzb_cfg_idx_e'(cfg_idx_i))
        CFG_SAFE_THR:    cfg_q.safe_threshold     <= cfg_data_i[15:0];
        CFG_WARNING_THR: cfg_q.warning_threshold  <= cfg_data_i[15:0];
        CFG_CAUTION_THR: cfg_q.caution_threshold  <= cfg_data_i[15:0];
        CFG_DANGER_THR:  cfg_q.danger_threshold   <= cfg_data_i[15:0];
        CFG_WARNING_PAT: cfg_q.warning_pattern    <= pzb_pattern_t'(cfg_data_i);
        CFG_CAUTION_PAT: cfg_q.caution_pattern    <= pzb_pattern_t'(cfg_data_i);
        CFG_DANGER_PAT:  cfg_q.danger_pattern     <= pzb_pattern_t'(cfg_data_i);
        CFG_CRIT_FREQ:   cfg_q.critical_frequency <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/pzb_zone_eval.sv
// Per-poll decision logic: zone classing, beep timing and next state.
// Purely combinational; depends on pzb_pkg for the payload and state types.
module pzb_zone_eval
  import pzb_pkg::*;
(
  input  pzb_cfg_t   cfg_i,
  input  pzb_in_t    poll_i,
  input  pzb_state_t state_i,
  output pzb_state_t state_o,
  output logic       emit_o,
  output pzb_out_t   result_o
);

  pzb_zone_e    zone;
  logic         zone_change;
  logic [31:0]  eff_last;
  logic         eff_on;
  pzb_pattern_t pat;
  logic [31:0]  elapsed;
  logic         period_met;
  logic         duration_met;

  // first threshold exceeded wins, whatever the ordering of the thresholds
  always_comb begin
    if (poll_i.distance > cfg_i.safe_threshold) begin
      zone = ZN_SAFE;
    end else if (poll_i.distance > cfg_i.warning_threshold) begin
      zone = ZN_WARNING;
    end else if (poll_i.distance > cfg_i.caution_threshold) begin
      zone = ZN_CAUTION;
    end else if (poll_i.distance > cfg_i.danger_threshold) begin
      zone = ZN_DANGER;
    end else begin
      zone = ZN_CRITICAL;
    end
  end

  assign zone_change = (zone != state_i.zone);
  assign eff_last    = zone_change ? poll_i.now_ms : state_i.last_toggle_ms;
  assign eff_on      = zone_change ? 1'b0 : state_i.beeper_on;

  always_comb begin
    case (zone)
      ZN_WARNING: pat = cfg_i.warning_pattern;
      ZN_CAUTION: pat = cfg_i.caution_pattern;
      default:    pat = cfg_i.danger_pattern;
    endcase
  end

  // elapsed time wraps modulo 2^32
  assign elapsed      = poll_i.now_ms - eff_last;
  assign period_met   = (elapsed >= {16'd0, pat.beep_period});
  assign duration_met = (elapsed >= {16'd0, pat.beep_len});

  always_comb begin
    state_o                 = state_i;
    emit_o                  = 1'b0;
    result_o.tone_frequency = 16'd0;
    result_o.tone_on        = 1'b0;
    result_o.zone           = zone;
    if (poll_i.sample_valid) begin
      state_o.zone           = zone;
      state_o.last_toggle_ms = eff_last;
      state_o.beeper_on      = eff_on;
      case (zone)
        ZN_CRITICAL: begin
          emit_o                  = 1'b1;
          result_o.tone_frequency = cfg_i.critical_frequency;
          result_o.tone_on        = 1'b1;
        end
        ZN_SAFE: begin
          emit_o = 1'b1;
        end
        default: begin
          if (!eff_on && period_met) begin
            emit_o                  = 1'b1;
            result_o.tone_frequency = pat.frequency;
            result_o.tone_on        = 1'b1;
            state_o.beeper_on       = 1'b1;
            state_o.last_toggle_ms  = poll_i.now_ms;
          end else if (eff_on && duration_met) begin
            emit_o            = 1'b1;
            state_o.beeper_on = 1'b0;
          end
        end
      endcase
    end
  end

endmodule

### rtl/proximity_zone_beeper.sv
// Proximity zone beeper: takes one distance poll per cycle when not stalled and
// produces at most one buzzer command per poll. A poll is captured in an input
// register, decided by the zone logic against the registered zone state and lands
// in the result register once the result slot is free or being drained. The block
// sustains one poll per clock while the output is not stalled; the zone state
// (zone, last toggle time, beeper flag) is updated as each poll is consumed. Polls
// that produce no result still pass through the input register.
// Depends on pzb_pkg, pzb_cfg_regs and pzb_zone_eval.
module proximity_zone_beeper
  import pzb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pzb_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pzb_out_t            out_data_o
);

  pzb_cfg_t   cfg;
  pzb_in_t    in_data_q;
  logic       in_valid_q;
  pzb_state_t state_q;
  pzb_state_t state_d;
  logic       emit;
  pzb_out_t   result;
  logic       out_valid_q;
  pzb_out_t   out_data_q;
  logic       advance;

  pzb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pzb_zone_eval u_eval (
    .cfg_i    (cfg),
    .poll_i   (in_data_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (result)
  );

  // the held beat moves on whenever the result slot is free or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.zone           <= ZN_SAFE;
      state_q.last_toggle_ms <= 32'd0;
      state_q.beeper_on      <= 1'b0;
      out_valid_q            <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_off_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tone_on |-> out_data_o.tone_frequency == 16'd0)
    else $error("silent result carries a nonzero frequency");

  a_beeper_middle_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.beeper_on |-> state_q.zone != ZN_SAFE && state_q.zone != ZN_CRITICAL)
    else $error("beeper flag set outside the beeping zones");

  a_critical_tone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zone == ZN_CRITICAL |-> out_data_o.tone_on)
    else $error("critical zone result without tone");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_valid_q) |=> $stable(state_q))
    else $error("zone state changed without a consumed poll");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline could move");

endmodule

### bench/proximity_zone_beeper_tb.sv
// Self-checking bench for proximity_zone_beeper: a queue-fed poll driver, a result
// monitor and a cycle-free beeper predictor that tracks zone, toggle time and flag.
// Depends on pzb_pkg and the proximity_zone_beeper RTL.
module proximity_zone_beeper_tb;
  import pzb_pkg::*;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pzb_in_t             in_data_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pzb_out_t            out_data_o;

  proximity_zone_beeper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the registers and the zone state
  pzb_cfg_t    cfg_model;
  pzb_zone_e   zone_q;
  logic [31:0] toggle_ms_q;
  logic        beeper_q;

  pzb_in_t  pending_polls[$];
  pzb_out_t beep_cmds_due[$];
  int       polls_in_flight = 0;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic [31:0] clock_ms;
  pzb_out_t pred_cmd;
  pzb_out_t want;

  function automatic pzb_zone_e zone_of(input logic [15:0] d);
    if (d > cfg_model.safe_threshold) return ZN_SAFE;
    if (d > cfg_model.warning_threshold) return ZN_WARNING;
    if (d > cfg_model.caution_threshold) return ZN_CAUTION;
    if (d > cfg_model.danger_threshold) return ZN_DANGER;
    return ZN_CRITICAL;
  endfunction

  function automatic bit predict_beep(input pzb_in_t poll, output pzb_out_t cmd);
    pzb_zone_e    z;
    pzb_pattern_t pat;
    logic [31:0]  elapsed;
    cmd = '0;
    if (!poll.sample_valid) return 1'b0;
    z = zone_of(poll.distance);
    if (z != zone_q) begin
      zone_q = z;
      toggle_ms_q = poll.now_ms;
      beeper_q = 1'b0;
    end
    cmd.zone = zone_q;
    case (zone_q)
      ZN_CRITICAL: begin
        cmd.tone_frequency = cfg_model.critical_frequency;
        cmd.tone_on = 1'b1;
        return 1'b1;
      end
      ZN_SAFE: begin
        return 1'b1;
      end
      default: begin
        if (zone_q == ZN_WARNING) pat = cfg_model.warning_pattern;
        else if (zone_q == ZN_CAUTION) pat = cfg_model.caution_pattern;
        else pat = cfg_model.danger_pattern;
        elapsed = poll.now_ms - toggle_ms_q;
        if (!beeper_q && elapsed >= 32'(pat.beep_period)) begin
          cmd.tone_frequency = pat.frequency;
          cmd.tone_on = 1'b1;
          beeper_q = 1'b1;
          toggle_ms_q = poll.now_ms;
          return 1'b1;
        end
        if (beeper_q && elapsed >= 32'(pat.beep_len)) begin
          beeper_q = 1'b0;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // mostly distances near a threshold so zone edges get hit often
  function automatic logic [15:0] pick_distance();
    int base;
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: base = int'(cfg_model.safe_threshold);
      2: base = int'(cfg_model.warning_threshold);
      3: base = int'(cfg_model.caution_threshold);
      4: base = int'(cfg_model.danger_threshold);
      default: base = int'($urandom_range(0, 1200));
    endcase
    base = base + int'($urandom_range(0, 4)) - 2;
    if (base < 0) base = 0;
    if (base > 65535) base = 65535;
    return 16'(base);
  endfunction

  task automatic add_poll(input logic [15:0] d, input logic v, input logic [31:0] t);
    pzb_in_t p;
    p.distance = d;
    p.sample_valid = v;
    p.now_ms = t;
    pending_polls.push_back(p);
    polls_in_flight++;
  endtask

  // runs of polls at a steady distance with time advancing, plus ignored noise
  task automatic queue_random_polls(input int count, input int step_max);
    int left;
    int run;
    logic [15:0] run_distance;
    left = count;
    while (left > 0) begin
      run_distance = pick_distance();
      run = int'($urandom_range(3, 20));
      for (int k = 0; k < run && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          add_poll(16'($urandom), 1'b0, $urandom);
        end else begin
          add_poll(run_distance, 1'b1, clock_ms);
          left--;
        end
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, step_max);
      end
    end
  endtask

  task automatic apply_config(input pzb_cfg_t c);
    logic [CfgDataW-1:0] regval [0:7];
    regval[CFG_SAFE_THR]    = 48'(c.safe_threshold);
    regval[CFG_WARNING_THR] = 48'(c.warning_threshold);
    regval[CFG_CAUTION_THR] = 48'(c.caution_threshold);
    regval[CFG_DANGER_THR]  = 48'(c.danger_threshold);
    regval[CFG_WARNING_PAT] = c.warning_pattern;
    regval[CFG_CAUTION_PAT] = c.caution_pattern;
    regval[CFG_DANGER_PAT]  = c.danger_pattern;
    regval[CFG_CRIT_FREQ]   = 48'(c.critical_frequency);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_data_i <= regval[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_model = c;
  endtask

  // poll driver: predicts each beat as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (predict_beep(in_data_i, pred_cmd)) beep_cmds_due.push_back(pred_cmd);
        polls_in_flight--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_polls.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i <= pending_polls.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (beep_cmds_due.size() == 0) begin
          $error("unexpected beat: tone_frequency %0d tone_on %0b zone %0d",
                 out_data_o.tone_frequency, out_data_o.tone_on, out_data_o.zone);
          mismatches++;
        end else begin
          want = beep_cmds_due.pop_front();
          if (out_data_o.tone_frequency !== want.tone_frequency) begin
            $error("tone_frequency: expected %0d actual %0d",
                   want.tone_frequency, out_data_o.tone_frequency);
            mismatches++;
          end
          if (out_data_o.tone_on !== want.tone_on) begin
            $error("tone_on: expected %0b actual %0b", want.tone_on, out_data_o.tone_on);
            mismatches++;
          end
          if (out_data_o.zone !== want.zone) begin
            $error("zone: expected %0d actual %0d", want.zone, out_data_o.zone);
            mismatches++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    pzb_cfg_t next_cfg;
    cfg_model.safe_threshold     = SafeThrRst;
    cfg_model.warning_threshold  = WarningThrRst;
    cfg_model.caution_threshold  = CautionThrRst;
    cfg_model.danger_threshold   = DangerThrRst;
    cfg_model.warning_pattern    = WarningPatRst;
    cfg_model.caution_pattern    = CautionPatRst;
    cfg_model.danger_pattern     = DangerPatRst;
    cfg_model.critical_frequency = CritFreqRst;
    zone_q = ZN_SAFE;
    toggle_ms_q = '0;
    beeper_q = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct  = (phase < 2) ? 35 : (phase < 4) ? 60 : 0;
      recv_stall_pct = (phase < 2) ? 60 : (phase < 4) ? 35 : 0;
      next_cfg = cfg_model;
      case (phase)
        1: begin
          next_cfg.safe_threshold    = 16'($urandom_range(2000, 6000));
          next_cfg.warning_threshold = 16'($urandom_range(1000, next_cfg.safe_threshold));
          next_cfg.caution_threshold = 16'($urandom_range(300, next_cfg.warning_threshold));
          next_cfg.danger_threshold  = 16'($urandom_range(0, next_cfg.caution_threshold));
          next_cfg.warning_pattern = '{16'($urandom_range(0, 400)),
                                       16'($urandom_range(0, 200)), 16'($urandom)};
          next_cfg.caution_pattern = '{16'($urandom_range(0, 400)),
                                       16'($urandom_range(0, 200)), 16'($urandom)};
          next_cfg.danger_pattern  = '{16'($urandom_range(0, 400)),
                                       16'($urandom_range(0, 200)), 16'($urandom)};
          next_cfg.critical_frequency = 16'($urandom);
        end
        2: next_cfg = '1;
        3: next_cfg = '0;
        4: begin
          // thresholds out of order, zero period and duration
          next_cfg.safe_threshold    = 16'd100;
          next_cfg.warning_threshold = 16'd1000;
          next_cfg.caution_threshold = 16'd50;
          next_cfg.danger_threshold  = 16'd2000;
          next_cfg.warning_pattern = '{16'd0, 16'd0, 16'($urandom)};
          next_cfg.caution_pattern = '{16'd0, 16'd0, 16'($urandom)};
          next_cfg.danger_pattern  = '{16'd0, 16'd0, 16'($urandom)};
          next_cfg.critical_frequency = 16'($urandom);
        end
        5: next_cfg = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        default: ;
      endcase
      if (phase != 0) apply_config(next_cfg);
      clock_ms = $urandom;

      case (phase)
        0: begin
          add_poll(16'd0, 1'b0, 32'd5);
          add_poll(16'hFFFF, 1'b1, 32'd0);
          add_poll(16'd801, 1'b1, 32'd1);
          add_poll(16'd800, 1'b1, 32'd10);
          add_poll(16'd800, 1'b1, 32'd1009);
          add_poll(16'd481, 1'b1, 32'd1010);
          add_poll(16'd700, 1'b1, 32'd1109);
          add_poll(16'd700, 1'b1, 32'd1110);
          add_poll(16'd480, 1'b1, 32'd2000);
          add_poll(16'd300, 1'b1, 32'd2500);
          add_poll(16'd241, 1'b1, 32'd2600);
          add_poll(16'd240, 1'b1, 32'd3000);
          add_poll(16'd81, 1'b1, 32'd3250);
          add_poll(16'd81, 1'b1, 32'd3330);
          add_poll(16'd80, 1'b1, 32'd3400);
          add_poll(16'd0, 1'b1, 32'd3401);
          add_poll(16'hFFFF, 1'b0, 32'hFFFF_FFFF);
          // elapsed time across the tick wrap
          add_poll(16'd100, 1'b1, 32'hFFFF_FF00);
          add_poll(16'd100, 1'b1, 32'h0000_0010);
          add_poll(16'd100, 1'b1, 32'hFFFF_FFFF);
        end
        3: begin
          add_poll(16'd0, 1'b1, clock_ms);
          add_poll(16'd1, 1'b1, clock_ms);
        end
        4: begin
          add_poll(16'd80, 1'b1, clock_ms);
          add_poll(16'd80, 1'b1, clock_ms);
          add_poll(16'd40, 1'b1, clock_ms);
        end
        default: ;
      endcase

      case (phase)
        0: queue_random_polls(150, 120);
        1: queue_random_polls(160, 150);
        2: queue_random_polls(100, 30000);
        3: queue_random_polls(100, 50);
        4: queue_random_polls(160, 50);
        default: queue_random_polls(160, 30000);
      endcase

      while (polls_in_flight != 0 || beep_cmds_due.size() != 0) @(posedge clk_i);
      // polls with no result may still be in the pipe
      repeat (4) @(posedge clk_i);
    end

    if (mismatches == 0 && beep_cmds_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(20 * 200000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
rtl/pzb_pkg.sv
rtl/pzb_cfg_regs.sv
rtl/pzb_zone_eval.sv
rtl/proximity_zone_beeper.sv
bench/proximity_zone_beeper_tb.sv
